@@ design/mmsl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmsl_pkg
// Shared constants and types of the min-max segment length search block.
// ----------------------------------------------------------------------------
package mmsl_pkg;

    localparam int MAX_LENGTHS  = 1024;
    localparam int LENGTH_BITS  = 30;
    localparam int BUDGET_BITS  = 30;
    localparam int OUT_BITS     = 30;
    localparam int ADDR_BITS    = $clog2(MAX_LENGTHS);
    localparam int COUNT_BITS   = $clog2(MAX_LENGTHS + 1);
    localparam int CUT_BITS     = BUDGET_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(LENGTH_BITS);
    localparam int S_DATA_BITS  = ((LENGTH_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS  = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_PROBE,
        ST_READ,
        ST_WAIT,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

@@ design/mmsl_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmsl_div
// Restoring divider, one quotient bit per cycle, registered quotient.
// ----------------------------------------------------------------------------
module mmsl_div
    import mmsl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [LENGTH_BITS-1:0] i_dividend,
    input  wire logic [LENGTH_BITS-1:0] i_divisor,
    output logic                        o_done,
    output logic [LENGTH_BITS-1:0]      o_quotient
);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic [LENGTH_BITS-1:0]  r_rem, n_rem;
    logic [LENGTH_BITS-1:0]  r_quo, n_quo;
    logic [LENGTH_BITS-1:0]  r_dsr, n_dsr;
    logic [LENGTH_BITS:0]    trial;
    logic                    fits;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        trial  = {r_rem, r_quo[LENGTH_BITS-1]};
        fits   = (trial >= {1'b0, r_dsr});
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? LENGTH_BITS'(trial - {1'b0, r_dsr})
                         : trial[LENGTH_BITS-1:0];
            n_quo = {r_quo[LENGTH_BITS-2:0], fits};
            n_cnt = r_cnt + DIV_CNT_BITS'(1);
            if (r_cnt == DIV_CNT_BITS'(LENGTH_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

@@ design/min_max_segment_length_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_max_segment_length_search
// Binary search for the smallest maximum piece length within a cut budget.
// ----------------------------------------------------------------------------
// Lengths stream in one per cycle while the block waits in its load state,
// and are written into a 1024-entry memory while the largest one is tracked;
// lengths past the memory size are dropped and flagged in tuser of the
// result. The request marked tlast starts the search, and no request is
// taken until its result has gone into the output register. Each probe of
// the search walks the stored lengths through one memory read port and a
// one-bit-per-cycle divider, one stored length at a time, and a probe ends
// early once the cut tally passes the budget. The search takes up to
// ceil(log2(max length)) probes.
// ----------------------------------------------------------------------------
module min_max_segment_length_search
    import mmsl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [BUDGET_BITS-1:0] i_cfg_wr_data,  // cut_budget
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [S_DATA_BITS-1:0] s_axis_tdata,   // [29:0] length_value
    input  wire logic                   s_axis_tlast,   // last_length
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [M_DATA_BITS-1:0]      m_axis_tdata,   // [29:0] best_piece_length
    output logic [0:0]                  m_axis_tuser    // [0] capacity_overflow
);

    t_state                 r_state, n_state;
    logic [BUDGET_BITS-1:0] r_budget;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [COUNT_BITS-1:0]  r_idx, n_idx;
    logic [LENGTH_BITS-1:0] r_max, n_max;
    logic                   r_ovf, n_ovf;
    logic [LENGTH_BITS-1:0] r_low, n_low;
    logic [LENGTH_BITS-1:0] r_high, n_high;
    logic [LENGTH_BITS-1:0] r_mid, n_mid;
    logic [CUT_BITS-1:0]    r_cuts, n_cuts;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0]    r_out_len, n_out_len;
    logic                   r_out_ovf, n_out_ovf;

    logic [LENGTH_BITS-1:0] mem [MAX_LENGTHS];
    logic [LENGTH_BITS-1:0] r_rd_data;
    logic                   mem_we, mem_re;
    logic [LENGTH_BITS-1:0] in_len;
    logic [LENGTH_BITS:0]   mid_sum;
    logic [CUT_BITS-1:0]    cut_sum;
    logic [LENGTH_BITS-1:0] dividend;
    logic                   div_start, div_done;
    logic [LENGTH_BITS-1:0] div_quo;

    assign in_len   = s_axis_tdata[LENGTH_BITS-1:0];
    assign mid_sum  = {1'b0, r_low} + {1'b0, r_high};
    assign cut_sum  = r_cuts + {1'b0, div_quo};
    assign dividend = (r_rd_data == '0) ? '0 : r_rd_data - LENGTH_BITS'(1);

    mmsl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_mid),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_max       = r_max;
        n_ovf       = r_ovf;
        n_low       = r_low;
        n_high      = r_high;
        n_mid       = r_mid;
        n_cuts      = r_cuts;
        n_out_valid = r_out_valid;
        n_out_len   = r_out_len;
        n_out_ovf   = r_out_ovf;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        div_start   = 1'b0;
        s_axis_tready = (r_state == ST_LOAD);

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_LOAD: begin
                if (s_axis_tvalid) begin
                    if (r_count < COUNT_BITS'(MAX_LENGTHS)) begin
                        mem_we  = 1'b1;
                        n_count = r_count + COUNT_BITS'(1);
                        if (in_len > r_max) begin
                            n_max = in_len;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_low   = LENGTH_BITS'(1);
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                n_high  = r_max;
                n_state = ST_PROBE;
            end
            ST_PROBE: begin
                if (r_low >= r_high) begin
                    n_state = ST_DONE;
                end else begin
                    n_mid   = mid_sum[LENGTH_BITS:1];
                    n_cuts  = '0;
                    n_idx   = '0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_idx == r_count) begin
                    n_high  = r_mid;
                    n_state = ST_PROBE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (cut_sum > {1'b0, r_budget}) begin
                        n_low   = r_mid + LENGTH_BITS'(1);
                        n_state = ST_PROBE;
                    end else begin
                        n_cuts  = cut_sum;
                        n_idx   = r_idx + COUNT_BITS'(1);
                        n_state = ST_READ;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_len   = OUT_BITS'(r_low);
                    n_out_ovf   = r_ovf;
                    n_count     = '0;
                    n_max       = '0;
                    n_ovf       = 1'b0;
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_budget    <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_max       <= '0;
            r_ovf       <= 1'b0;
            r_low       <= LENGTH_BITS'(1);
            r_high      <= '0;
            r_cuts      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_wr_en) begin
                r_budget <= i_cfg_wr_data;
            end
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_max       <= n_max;
            r_ovf       <= n_ovf;
            r_low       <= n_low;
            r_high      <= n_high;
            r_cuts      <= n_cuts;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid     <= n_mid;
        r_out_len <= n_out_len;
        r_out_ovf <= n_out_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[ADDR_BITS-1:0]] <= in_len;
        end
        if (mem_re) begin
            r_rd_data <= mem[r_idx[ADDR_BITS-1:0]];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_DATA_BITS'(r_out_len);
    assign m_axis_tuser  = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_BITS'(MAX_LENGTHS))
        else $error("stored count past memory size");

    a_cuts_in_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_cuts <= {1'b0, r_budget}))
        else $error("probe continued past the cut budget");

    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_low <= r_mid && r_mid < r_high))
        else $error("probe length outside search window");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside divide state");

endmodule
`default_nettype wire
